// File: rtl/phase_dispersion_theta_unit_macros.svh
// assertion helpers for the theta unit checker
`ifndef PHASE_DISPERSION_THETA_UNIT_MACROS_SVH
`define PHASE_DISPERSION_THETA_UNIT_MACROS_SVH

// assert an implication on every clock edge outside reset
`define PDT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdt check failed");

// assert an implication whose consequent must hold in the cycle after the antecedent
`define PDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdt check failed");

`endif

// File: rtl/pdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pdt_pkg;

  typedef struct packed {
    logic        opcode;
    logic        first_obs;
    logic [39:0] obs_time;
    logic signed [23:0] obs_magnitude;
    logic [39:0] frequency;
  } pdt_in_t;

  typedef struct packed {
    logic [31:0] theta_ratio;
    logic [1:0]  status;
  } pdt_out_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam int TIME_W = 40;
  localparam int MAG_W  = 24;
  localparam int SUM_W  = 64;

  // divider handshake
  typedef struct packed {
    logic start;
  } pdt_div_ctl_t;

  typedef struct packed {
    logic done;
  } pdt_div_sts_t;

endpackage
`default_nettype wire

// File: rtl/pdt_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// registered 25x25 unsigned multiplier, one product per cycle
module pdt_mul (
  input  wire logic        clk,
  input  wire logic [24:0] a,
  input  wire logic [24:0] b,
  output logic [49:0]      p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
`default_nettype wire

// File: rtl/pdt_div.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divider of num<<16 by den: 48 overflow steps then 32 quotient bits
module pdt_div
  import pdt_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pdt_div_ctl_t  ctl,
  input  wire logic [63:0]   num,
  input  wire logic [63:0]   den,
  output pdt_div_sts_t       sts,
  output logic [31:0]        quo_r,
  output logic               sat_r
);
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] num_r, num_nxt;
  logic [31:0] quo_nxt;
  logic        sat_nxt;
  logic [64:0] trial;
  logic        done_nxt, done_r;

  // 80-bit dividend num<<16, quotient must fit in 32 bits
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    sat_nxt  = sat_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd0;
      rem_nxt  = '0;
      num_nxt  = num;
      quo_nxt  = '0;
      sat_nxt  = 1'b0;
    end else if (busy_r) begin
      trial = {rem_r, (cnt_r < 7'd64) ? num_r[63] : 1'b0};
      num_nxt = {num_r[62:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_nxt = 64'(trial - {1'b0, den});
        if (cnt_r < 7'd48) begin
          sat_nxt = 1'b1;
        end else begin
          quo_nxt = {quo_r[30:0], 1'b1};
        end
      end else begin
        rem_nxt = trial[63:0];
        if (cnt_r >= 7'd48) begin
          quo_nxt = {quo_r[30:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd79) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    sat_r <= sat_nxt;
  end

  assign sts.done = done_r;
endmodule
`default_nettype wire

// File: rtl/phase_dispersion_theta_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// phase dispersion theta unit
// input channel in_valid/in_stall/in_data: a load request stores one
// observation (first_obs restarts the set, loads beyond MAX_OBS are dropped);
// an evaluate request brings a trial frequency and yields one result on
// out_valid/out_stall/out_data, loads yield none.
// cfg_we/cfg_wdata write the mean magnitude; the user must write it only
// while the unit is idle, as the unit itself does not enforce this.
// an evaluate runs a phase pass (a deviation square and three partial
// products per observation through the shared multiplier), ceil(log2 n)
// merge passes over the n observations (none for n below 2), the
// difference sum and the divider (skipped when the difference sum is
// zero), then raises out_valid. one request at a time: in_stall is high
// from an evaluate until its result is taken, and the next request can be
// accepted in the cycle after; loads never raise in_stall.
// after reset the set is empty and the mean is zero; no clearing pass.
// a stalled result holds in the output register until out_stall falls.
module phase_dispersion_theta_unit
  import pdt_pkg::*;
#(
  parameter int MAX_OBS    = 1024,
  parameter int PHASE_BITS = 24
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pdt_in_t       in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pdt_out_t           out_data,
  input  wire logic          cfg_we,
  input  wire logic [23:0]   cfg_wdata
);
  localparam int AW = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1;
  localparam int CW = AW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PH0   = 4'd1;
  localparam logic [3:0] S_PH1   = 4'd2;
  localparam logic [3:0] S_PH2   = 4'd3;
  localparam logic [3:0] S_PH3   = 4'd4;
  localparam logic [3:0] S_MRD   = 4'd5;
  localparam logic [3:0] S_MCMP  = 4'd6;
  localparam logic [3:0] S_SRD   = 4'd7;
  localparam logic [3:0] S_SACC  = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_MCPY  = 4'd11;
  localparam logic [3:0] S_SMUL  = 4'd12;
  localparam logic [3:0] S_ADDW  = 4'd13;

  // memories
  logic [TIME_W-1:0]     time_mem  [MAX_OBS];
  logic [MAG_W-1:0]      mag_mem   [MAX_OBS];
  logic [PHASE_BITS-1:0] phase_mem [MAX_OBS];
  logic [AW-1:0]         ord_a     [MAX_OBS];
  logic [AW-1:0]         ord_b     [MAX_OBS];

  logic [3:0]  state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [MAG_W-1:0] mean_r;
  logic [39:0] freq_r, freq_nxt;
  logic [39:0] t0_r, t0_nxt;

  // loop registers
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] width_r, width_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mi_r, mi_nxt;   // left cursor
  logic [CW-1:0] mj_r, mj_nxt;   // right cursor
  logic [CW-1:0] k_r, k_nxt;
  logic          srcb_r, srcb_nxt; // 1: current order lives in ord_b
  logic [63:0]   num_r, num_nxt;
  logic [63:0]   den_r, den_nxt;
  logic [47:0]   frac_r, frac_nxt;
  logic          neg_r, neg_nxt;
  logic [39:0]   dlt_r, dlt_nxt;
  logic [MAG_W-1:0] prev_mag_r, prev_mag_nxt;
  logic          numdone_r, numdone_nxt;
  pdt_out_t      out_r, out_nxt;
  logic          outv_r, outv_nxt;

  // memory read ports (registered)
  logic [AW-1:0] ra_addr, rb_addr;
  logic [AW-1:0] ord_ra_r, ord_rb_r;
  logic [PHASE_BITS-1:0] ph_a_r, ph_b_r;
  logic [TIME_W-1:0] time_rd_r;
  logic [MAG_W-1:0]  mag_rd_r;
  logic [AW-1:0]     t_addr;
  logic [AW-1:0]     m_addr;

  // writes
  logic          time_we;
  logic [AW-1:0] time_wa;
  logic          ph_we;
  logic [AW-1:0] ph_wa;
  logic [PHASE_BITS-1:0] ph_wd;
  logic          oa_we, ob_we;
  logic [AW-1:0] o_wa;
  logic [AW-1:0] o_wd;

  // shared multiplier
  logic [24:0] mul_a, mul_b;
  logic [49:0] mul_p;

  pdt_div_ctl_t div_ctl;
  pdt_div_sts_t div_sts;
  logic [31:0]  div_q;
  logic         div_sat;

  pdt_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  pdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (num_r),
    .den   (den_r),
    .sts   (div_sts),
    .quo_r (div_q),
    .sat_r (div_sat)
  );

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // sort cursor bounds
  logic [CW:0] mid_w, hi_w;
  logic [CW-1:0] mid_c, hi_c;
  always_comb begin
    mid_w = {1'b0, lo_r} + {1'b0, width_r};
    hi_w  = {1'b0, lo_r} + {width_r, 1'b0};
    mid_c = (mid_w > {1'b0, cnt_r}) ? cnt_r : mid_w[CW-1:0];
    hi_c  = (hi_w > {1'b0, cnt_r}) ? cnt_r : hi_w[CW-1:0];
  end

  logic signed [MAG_W:0] dev;
  logic [MAG_W:0] dev_abs;
  logic [47:0] frac_fin;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    freq_nxt     = freq_r;
    t0_nxt       = t0_r;
    i_nxt        = i_r;
    width_nxt    = width_r;
    lo_nxt       = lo_r;
    mi_nxt       = mi_r;
    mj_nxt       = mj_r;
    k_nxt        = k_r;
    srcb_nxt     = srcb_r;
    num_nxt      = num_r;
    den_nxt      = den_r;
    frac_nxt     = frac_r;
    neg_nxt      = neg_r;
    dlt_nxt      = dlt_r;
    prev_mag_nxt = prev_mag_r;
    numdone_nxt  = numdone_r;
    out_nxt      = out_r;
    outv_nxt     = outv_r;
    time_we      = 1'b0;
    time_wa      = cnt_r[AW-1:0];
    ph_we        = 1'b0;
    ph_wa        = i_r[AW-1:0];
    ph_wd        = '0;
    oa_we        = 1'b0;
    ob_we        = 1'b0;
    o_wa         = i_r[AW-1:0];
    o_wd         = i_r[AW-1:0];
    ra_addr      = mi_r[AW-1:0];
    rb_addr      = mj_r[AW-1:0];
    t_addr       = i_r[AW-1:0];
    m_addr       = i_r[AW-1:0];
    mul_a        = '0;
    mul_b        = '0;
    div_ctl.start = 1'b0;
    dev          = '0;
    dev_abs      = '0;
    frac_fin     = '0;

    unique case (state_r)
      S_IDLE: begin
        t_addr = '0;
        if (accept) begin
          if (in_data.opcode == OP_LOAD) begin
            if (in_data.first_obs) begin
              time_we = 1'b1;
              time_wa = '0;
              cnt_nxt = {{(CW-1){1'b0}}, 1'b1};
            end else if (cnt_r < CW'(MAX_OBS)) begin
              time_we = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end
          end else begin
            freq_nxt = in_data.frequency;
            i_nxt    = '0;
            num_nxt  = '0;
            den_nxt  = '0;
            state_nxt = S_PH0;
          end
        end
      end
      // phase pass: read time[i], t0 captured from entry 0
      S_PH0: begin
        if (i_r == cnt_r) begin
          i_nxt     = '0;
          width_nxt = {{(CW-1){1'b0}}, 1'b1};
          lo_nxt    = '0;
          srcb_nxt  = 1'b0;
          if (cnt_r > {{(CW-1){1'b0}}, 1'b1}) begin
            mi_nxt = '0;
            mj_nxt = {{(CW-1){1'b0}}, 1'b1};
            k_nxt  = '0;
            state_nxt = S_MRD;
          end else begin
            state_nxt = S_SRD;
          end
        end else begin
          state_nxt = S_PH1;
        end
      end
      S_PH1: begin
        if (i_r == '0) begin
          t0_nxt = time_rd_r;
          dlt_nxt = '0;
          neg_nxt = 1'b0;
        end else if (time_rd_r >= t0_r) begin
          dlt_nxt = time_rd_r - t0_r;
          neg_nxt = 1'b0;
        end else begin
          dlt_nxt = t0_r - time_rd_r;
          neg_nxt = 1'b1;
        end
        // deviation square for numerator
        dev = $signed({mag_rd_r[MAG_W-1], mag_rd_r}) - $signed({mean_r[MAG_W-1], mean_r});
        dev_abs = dev[MAG_W] ? (MAG_W+1)'(-dev) : dev;
        mul_a = dev_abs;
        mul_b = dev_abs;
        state_nxt = S_PH2;
      end
      // products: d*f modulo 2^48 (d[23:0]*f[23:0] first), split into 3 pieces
      S_PH2: begin
        num_nxt = num_r + 64'(mul_p);
        // d[23:0] * f[23:0]
        mul_a = {1'b0, dlt_r[23:0]};
        mul_b = {1'b0, freq_r[23:0]};
        state_nxt = S_PH3;
        frac_nxt = '0;
        k_nxt = '0;
      end
      S_PH3: begin
        // sequence through partial products; k_r counts
        unique case (k_r[1:0])
          2'd0: begin
            frac_nxt = mul_p[47:0];
            // d[39:24] * f[23:0] << 24
            mul_a = {9'd0, dlt_r[39:24]};
            mul_b = {1'b0, freq_r[23:0]};
            k_nxt = CW'(1);
          end
          2'd1: begin
            frac_nxt = frac_r + {mul_p[23:0], 24'd0};
            // d[23:0] * f[39:24] << 24
            mul_a = {1'b0, dlt_r[23:0]};
            mul_b = {9'd0, freq_r[39:24]};
            k_nxt = CW'(2);
          end
          default: begin
            frac_fin = frac_r + {mul_p[23:0], 24'd0};
            if (neg_r) begin
              frac_fin = 48'd0 - frac_fin;
            end
            ph_we = 1'b1;
            ph_wd = frac_fin[47 -: PHASE_BITS];
            oa_we = 1'b1;
            k_nxt = '0;
            i_nxt = i_r + CW'(1);
            state_nxt = S_PH0;
          end
        endcase
      end
      // merge: read order at cursors, then phases
      S_MRD: begin
        state_nxt = S_MCMP;
      end
      S_MCMP: begin
        // ord_ra_r/ord_rb_r valid; phases are read from them into ph_a_r/ph_b_r, used in S_MCPY
        state_nxt = S_MCPY;
      end
      S_MCPY: begin
        o_wa = k_r[AW-1:0];
        if (mi_r < mid_c && (mj_r >= hi_c || ph_a_r <= ph_b_r)) begin
          o_wd = ord_ra_r;
          mi_nxt = mi_r + CW'(1);
        end else begin
          o_wd = ord_rb_r;
          mj_nxt = mj_r + CW'(1);
        end
        if (srcb_r) begin
          oa_we = 1'b1;
        end else begin
          ob_we = 1'b1;
        end
        k_nxt = k_r + CW'(1);
        state_nxt = S_MRD;
        if (k_r + CW'(1) == hi_c) begin
          if (hi_c == cnt_r) begin
            lo_nxt = '0;
            srcb_nxt = !srcb_r;
            width_nxt = {width_r[CW-2:0], 1'b0};
            if ({1'b0, width_r, 1'b0} >= {2'b0, cnt_r}) begin
              i_nxt = '0;
              state_nxt = S_SRD;
              srcb_nxt = !srcb_r;
            end
            mi_nxt = '0;
            mj_nxt = {width_r[CW-2:0], 1'b0};
            k_nxt = '0;
          end else begin
            lo_nxt = hi_c;
            mi_nxt = hi_c;
            mj_nxt = CW'({1'b0, hi_c} + {1'b0, width_r});
            k_nxt  = hi_c;
          end
        end
      end
      // sum of squared adjacent differences over sorted order
      S_SRD: begin
        ra_addr = i_r[AW-1:0];
        if (i_r == cnt_r) begin
          numdone_nxt = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_SMUL;
        end
      end
      S_SMUL: begin
        m_addr = ord_ra_r;
        state_nxt = S_SACC;
      end
      S_SACC: begin
        dev = $signed({mag_rd_r[MAG_W-1], mag_rd_r})
            - $signed({prev_mag_r[MAG_W-1], prev_mag_r});
        dev_abs = dev[MAG_W] ? (MAG_W+1)'(-dev) : dev;
        prev_mag_nxt = mag_rd_r;
        if (i_r != '0) begin
          mul_a = dev_abs;
          mul_b = dev_abs;
        end
        i_nxt = i_r + CW'(1);
        state_nxt = S_ADDW;
      end
      S_ADDW: begin
        den_nxt = den_r + 64'(mul_p);
        state_nxt = S_SRD;
      end
      S_DIV: begin
        if (numdone_r) begin
          numdone_nxt = 1'b0;
          if (den_r == '0) begin
            out_nxt.theta_ratio = '0;
            out_nxt.status = ST_ZERO;
            outv_nxt = 1'b1;
            state_nxt = S_OUT;
          end else begin
            div_ctl.start = 1'b1;
          end
        end else if (div_sts.done) begin
          if (div_sat) begin
            out_nxt.theta_ratio = '1;
            out_nxt.status = ST_SAT;
          end else begin
            out_nxt.theta_ratio = div_q;
            out_nxt.status = ST_OK;
          end
          outv_nxt = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          outv_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // read address for the phase pass time reads
  logic [AW-1:0] t_rd_addr;
  assign t_rd_addr = (state_r == S_IDLE) ? '0 : t_addr;

  always_ff @(posedge clk) begin
    if (time_we) begin
      time_mem[time_wa] <= in_data.obs_time;
      mag_mem[time_wa]  <= in_data.obs_magnitude;
    end
    if (ph_we) begin
      phase_mem[ph_wa] <= ph_wd;
    end
    if (oa_we) begin
      ord_a[o_wa] <= o_wd;
    end
    if (ob_we) begin
      ord_b[o_wa] <= o_wd;
    end
    time_rd_r <= time_mem[t_rd_addr];
    mag_rd_r  <= mag_mem[m_addr];
    ord_ra_r  <= srcb_r ? ord_b[ra_addr] : ord_a[ra_addr];
    ord_rb_r  <= srcb_r ? ord_b[rb_addr] : ord_a[rb_addr];
    ph_a_r    <= phase_mem[ord_ra_r];
    ph_b_r    <= phase_mem[ord_rb_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      mean_r    <= '0;
      outv_r    <= 1'b0;
      numdone_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      outv_r    <= outv_nxt;
      numdone_r <= numdone_nxt;
      if (cfg_we) begin
        mean_r <= cfg_wdata;
      end
    end
    freq_r     <= freq_nxt;
    t0_r       <= t0_nxt;
    i_r        <= i_nxt;
    width_r    <= width_nxt;
    lo_r       <= lo_nxt;
    mi_r       <= mi_nxt;
    mj_r       <= mj_nxt;
    k_r        <= k_nxt;
    srcb_r     <= srcb_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    frac_r     <= frac_nxt;
    neg_r      <= neg_nxt;
    dlt_r      <= dlt_nxt;
    prev_mag_r <= prev_mag_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = outv_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

// File: rtl/pdt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "phase_dispersion_theta_unit_macros.svh"
module pdt_checker
  import pdt_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire pdt_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire pdt_out_t out_data
);
  `PDT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `PDT_ASSERT_IMPL(a_busy_out, clk, rst_n, out_valid, in_stall)
  `PDT_ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_data.status != 2'd3)
  `PDT_ASSERT_IMPL(a_sat_all_ones, clk, rst_n, out_valid && out_data.status == ST_SAT, out_data.theta_ratio == 32'hFFFFFFFF)
  `PDT_ASSERT_NEXT(a_eval_busy, clk, rst_n, in_valid && !in_stall && in_data.opcode == OP_EVAL, in_stall)
endmodule

bind phase_dispersion_theta_unit pdt_checker u_pdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
